@@ rtl/gcm_pkg.sv @@
// shared types, palette tables and helpers for the gradient colour map
package gcm_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_STOPS_DEF = 8;

  localparam int LEVEL_W       = 18;
  localparam int CHAN_W        = 8;
  localparam int PAL_W         = 3;
  localparam int STOP_IDX_W    = 3;
  localparam int STOP_CNT_W    = 4;
  localparam int PALETTE_COUNT = 5;
  localparam int TABLE_STOPS   = 8;

  localparam logic [PAL_W-1:0] PAL_SPECTRUM = PAL_W'(0);

  typedef struct packed {
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
  } rgb_t;

  typedef struct packed {
    logic r;
    logic g;
    logic b;
  } rgb_dir_t;

  localparam rgb_t BLACK = '{r: 8'd0, g: 8'd0, b: 8'd0};
  localparam rgb_t WHITE = '{r: 8'd255, g: 8'd255, b: 8'd255};

  localparam rgb_t PALETTE [PALETTE_COUNT][TABLE_STOPS] = '{
    '{BLACK, '{8'd255, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd0}, '{8'd0, 8'd255, 8'd0},
      '{8'd0, 8'd255, 8'd255}, '{8'd0, 8'd0, 8'd255}, '{8'd255, 8'd0, 8'd255}, WHITE},
    '{BLACK, '{8'd0, 8'd0, 8'd255}, '{8'd0, 8'd255, 8'd0}, '{8'd255, 8'd0, 8'd0},
      BLACK, BLACK, BLACK, BLACK},
    '{WHITE, '{8'd50, 8'd27, 8'd118}, '{8'd255, 8'd255, 8'd35}, BLACK,
      BLACK, BLACK, BLACK, BLACK},
    '{WHITE, BLACK, BLACK, BLACK, BLACK, BLACK, BLACK, BLACK},
    '{BLACK, '{8'd255, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd0}, WHITE,
      BLACK, BLACK, BLACK, BLACK}
  };

  localparam logic [STOP_CNT_W-1:0] PAL_STOPS [PALETTE_COUNT] = '{
    4'd8, 4'd4, 4'd4, 4'd2, 4'd4
  };

  function automatic rgb_t palette_stop(input logic [PAL_W-1:0] pal,
                                        input logic [STOP_IDX_W-1:0] idx);
    palette_stop = PALETTE[pal][idx];
  endfunction

endpackage

@@ rtl/gcm_clamp.sv @@
// first stage: clamps the level to 0..1.0 and resolves palette and region count
module gcm_clamp #(
  parameter int FRAC_BITS = gcm_pkg::FRAC_BITS_DEF,
  parameter int MAX_STOPS = gcm_pkg::MAX_STOPS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  logic signed [gcm_pkg::LEVEL_W-1:0]   level_i,
  input  logic [gcm_pkg::PAL_W-1:0]            palette_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output logic [FRAC_BITS:0]                   value_o,
  output logic [gcm_pkg::PAL_W-1:0]            pal_o,
  output logic [gcm_pkg::STOP_IDX_W-1:0]       regions_o
);

  localparam int CW = (FRAC_BITS + 2 > gcm_pkg::LEVEL_W) ? FRAC_BITS + 2 : gcm_pkg::LEVEL_W;
  localparam logic signed [CW-1:0] ONE = CW'(1) <<< FRAC_BITS;

  logic signed [CW-1:0]                  lvl_ext;
  logic [FRAC_BITS:0]                    value_d, value_q;
  logic [gcm_pkg::PAL_W-1:0]             pal_d, pal_q;
  logic [gcm_pkg::STOP_CNT_W-1:0]        stops;
  logic [gcm_pkg::STOP_IDX_W-1:0]        regions_d, regions_q;
  logic                                  valid_q;

  assign lvl_ext = CW'(level_i);

  always_comb begin
    if (lvl_ext < 0) begin
      value_d = '0;
    end else if (lvl_ext > ONE) begin
      value_d = ONE[FRAC_BITS:0];
    end else begin
      value_d = lvl_ext[FRAC_BITS:0];
    end
  end

  always_comb begin
    pal_d = (palette_i >= gcm_pkg::PAL_W'(gcm_pkg::PALETTE_COUNT)) ? gcm_pkg::PAL_SPECTRUM
                                                                    : palette_i;
    stops = gcm_pkg::PAL_STOPS[pal_d];
    if (stops > gcm_pkg::STOP_CNT_W'(MAX_STOPS)) begin
      stops = gcm_pkg::STOP_CNT_W'(MAX_STOPS);
    end
    regions_d = gcm_pkg::STOP_IDX_W'(stops - gcm_pkg::STOP_CNT_W'(1));
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      value_q   <= value_d;
      pal_q     <= pal_d;
      regions_q <= regions_d;
    end
  end

  assign valid_o   = valid_q;
  assign value_o   = value_q;
  assign pal_o     = pal_q;
  assign regions_o = regions_q;

endmodule

@@ rtl/gcm_segment.sv @@
// second stage: scales by region count, picks the segment and fetches its stops
module gcm_segment #(
  parameter int FRAC_BITS = gcm_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  logic [FRAC_BITS:0]               value_i,
  input  logic [gcm_pkg::PAL_W-1:0]        pal_i,
  input  logic [gcm_pkg::STOP_IDX_W-1:0]   regions_i,
  output logic                             valid_o,
  input  logic                             ready_i,
  output gcm_pkg::rgb_t                    lower_o,
  output gcm_pkg::rgb_t                    span_o,
  output gcm_pkg::rgb_dir_t                dir_o,
  output logic [FRAC_BITS-1:0]             frac_o
);

  localparam int SW = FRAC_BITS + 4;

  logic [SW-1:0]                        scaled;
  logic [gcm_pkg::STOP_IDX_W-1:0]       seg;
  logic                                 last;
  gcm_pkg::rgb_t                        lo, hi;
  gcm_pkg::rgb_t                        lower_q, span_d, span_q;
  gcm_pkg::rgb_dir_t                    dir_d, dir_q;
  logic [FRAC_BITS-1:0]                 frac_q;
  logic                                 valid_q;

  assign scaled = SW'(value_i) * SW'(regions_i);
  assign seg    = scaled[FRAC_BITS +: gcm_pkg::STOP_IDX_W];
  assign last   = seg >= regions_i;

  always_comb begin
    lo = gcm_pkg::palette_stop(pal_i, last ? regions_i : seg);
    hi = last ? lo : gcm_pkg::palette_stop(pal_i, seg + gcm_pkg::STOP_IDX_W'(1));
    dir_d.r  = hi.r < lo.r;
    dir_d.g  = hi.g < lo.g;
    dir_d.b  = hi.b < lo.b;
    span_d.r = dir_d.r ? lo.r - hi.r : hi.r - lo.r;
    span_d.g = dir_d.g ? lo.g - hi.g : hi.g - lo.g;
    span_d.b = dir_d.b ? lo.b - hi.b : hi.b - lo.b;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      lower_q <= lo;
      span_q  <= span_d;
      dir_q   <= dir_d;
      frac_q  <= scaled[FRAC_BITS-1:0];
    end
  end

  assign valid_o = valid_q;
  assign lower_o = lower_q;
  assign span_o  = span_q;
  assign dir_o   = dir_q;
  assign frac_o  = frac_q;

endmodule

@@ rtl/gcm_scale.sv @@
// third stage: multiplies each channel span by the blend fraction
module gcm_scale #(
  parameter int FRAC_BITS = gcm_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  gcm_pkg::rgb_t         lower_i,
  input  gcm_pkg::rgb_t         span_i,
  input  gcm_pkg::rgb_dir_t     dir_i,
  input  logic [FRAC_BITS-1:0]  frac_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output gcm_pkg::rgb_t         lower_o,
  output gcm_pkg::rgb_t         part_o,
  output gcm_pkg::rgb_dir_t     dir_o
);

  localparam int PW = FRAC_BITS + gcm_pkg::CHAN_W;

  logic [PW-1:0]      prod_r, prod_g, prod_b;
  gcm_pkg::rgb_t      part_d, part_q, lower_q;
  gcm_pkg::rgb_dir_t  dir_q;
  logic               valid_q;

  assign prod_r = PW'(span_i.r) * PW'(frac_i);
  assign prod_g = PW'(span_i.g) * PW'(frac_i);
  assign prod_b = PW'(span_i.b) * PW'(frac_i);

  assign part_d.r = prod_r[FRAC_BITS +: gcm_pkg::CHAN_W];
  assign part_d.g = prod_g[FRAC_BITS +: gcm_pkg::CHAN_W];
  assign part_d.b = prod_b[FRAC_BITS +: gcm_pkg::CHAN_W];

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      lower_q <= lower_i;
      part_q  <= part_d;
      dir_q   <= dir_i;
    end
  end

  assign valid_o = valid_q;
  assign lower_o = lower_q;
  assign part_o  = part_q;
  assign dir_o   = dir_q;

endmodule

@@ rtl/gcm_mix.sv @@
// last stage: adds or subtracts the scaled part and holds the output colour
module gcm_mix (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  gcm_pkg::rgb_t      lower_i,
  input  gcm_pkg::rgb_t      part_i,
  input  gcm_pkg::rgb_dir_t  dir_i,
  output logic               valid_o,
  input  logic               ready_i,
  output gcm_pkg::rgb_t      colour_o
);

  gcm_pkg::rgb_t  colour_d, colour_q;
  logic           valid_q;

  assign colour_d.r = dir_i.r ? lower_i.r - part_i.r : lower_i.r + part_i.r;
  assign colour_d.g = dir_i.g ? lower_i.g - part_i.g : lower_i.g + part_i.g;
  assign colour_d.b = dir_i.b ? lower_i.b - part_i.b : lower_i.b + part_i.b;

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      colour_q <= colour_d;
    end
  end

  assign valid_o  = valid_q;
  assign colour_o = colour_q;

endmodule

@@ rtl/gradient_colour_map.sv @@
// gradient colour map top level: level in, blended rgb colour out
//
// Maps a signed fixed-point level (FRAC_BITS fraction bits, clamped to 0..1.0)
// to an RGB colour by linear blending between the stops of one of five built-in
// palettes, chosen by palette_select (values above 4 give the spectrum). The
// block is a four-stage pipeline: clamp and palette lookup, segment scaling
// and stop fetch, span-by-fraction multiply, then blend into the output
// register. One transfer is accepted per clock while the output side does not
// stall; each colour passes the clamp, segment, scale and mix registers
// before it reaches the outputs, and a stall backs up through the stage
// valid bits without loss. Write palette_select only while no transfer is
// in flight.
module gradient_colour_map #(
  parameter int FRAC_BITS = gcm_pkg::FRAC_BITS_DEF,
  parameter int MAX_STOPS = gcm_pkg::MAX_STOPS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [gcm_pkg::PAL_W-1:0]           palette_select_i,
  input  logic                                level_valid_i,
  output logic                                level_ready_o,
  input  logic signed [gcm_pkg::LEVEL_W-1:0]  level_i,
  output logic                                rgb_valid_o,
  input  logic                                rgb_ready_i,
  output logic [gcm_pkg::CHAN_W-1:0]          red_o,
  output logic [gcm_pkg::CHAN_W-1:0]          green_o,
  output logic [gcm_pkg::CHAN_W-1:0]          blue_o
);

  logic [gcm_pkg::PAL_W-1:0]       palette_q;

  logic                            s1_valid, s1_ready;
  logic [FRAC_BITS:0]              s1_value;
  logic [gcm_pkg::PAL_W-1:0]       s1_pal;
  logic [gcm_pkg::STOP_IDX_W-1:0]  s1_regions;

  logic                            s2_valid, s2_ready;
  gcm_pkg::rgb_t                   s2_lower, s2_span;
  gcm_pkg::rgb_dir_t               s2_dir;
  logic [FRAC_BITS-1:0]            s2_frac;

  logic                            s3_valid, s3_ready;
  gcm_pkg::rgb_t                   s3_lower, s3_part;
  gcm_pkg::rgb_dir_t               s3_dir;

  gcm_pkg::rgb_t                   colour;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palette_q <= '0;
    end else if (cfg_valid_i) begin
      palette_q <= palette_select_i;
    end
  end

  gcm_clamp #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_STOPS (MAX_STOPS)
  ) u_clamp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (level_valid_i),
    .ready_o   (level_ready_o),
    .level_i   (level_i),
    .palette_i (palette_q),
    .valid_o   (s1_valid),
    .ready_i   (s1_ready),
    .value_o   (s1_value),
    .pal_o     (s1_pal),
    .regions_o (s1_regions)
  );

  gcm_segment #(
    .FRAC_BITS (FRAC_BITS)
  ) u_segment (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s1_valid),
    .ready_o   (s1_ready),
    .value_i   (s1_value),
    .pal_i     (s1_pal),
    .regions_i (s1_regions),
    .valid_o   (s2_valid),
    .ready_i   (s2_ready),
    .lower_o   (s2_lower),
    .span_o    (s2_span),
    .dir_o     (s2_dir),
    .frac_o    (s2_frac)
  );

  gcm_scale #(
    .FRAC_BITS (FRAC_BITS)
  ) u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .lower_i (s2_lower),
    .span_i  (s2_span),
    .dir_i   (s2_dir),
    .frac_i  (s2_frac),
    .valid_o (s3_valid),
    .ready_i (s3_ready),
    .lower_o (s3_lower),
    .part_o  (s3_part),
    .dir_o   (s3_dir)
  );

  gcm_mix u_mix (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s3_valid),
    .ready_o  (s3_ready),
    .lower_i  (s3_lower),
    .part_i   (s3_part),
    .dir_i    (s3_dir),
    .valid_o  (rgb_valid_o),
    .ready_i  (rgb_ready_i),
    .colour_o (colour)
  );

  assign red_o   = colour.r;
  assign green_o = colour.g;
  assign blue_o  = colour.b;

endmodule
